FILE: hdl/tsq_pkg.sv
// ----------------------------------------------------------------------------
// tsq_pkg
// Types, register map and pitch helpers shared by the step sequencer files.
// ----------------------------------------------------------------------------
package tsq_pkg;

    localparam int LANES       = 8;
    localparam int LEVEL_MAX   = 12;
    localparam int THRESH_MV   = 1000;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 56;
    localparam int PADDR_W     = 5;

    localparam logic [3:0]  STEP_SETTING_RST = 4'd8;
    localparam logic [31:0] PHASE_INC_RST    = 32'd389566;

    typedef enum logic [2:0] {
        REG_ROW_ONE   = 3'd0,
        REG_ROW_TWO   = 3'd1,
        REG_ROW_THREE = 3'd2,
        REG_MODES     = 3'd3,
        REG_STEPS     = 3'd4,
        REG_PHASE_INC = 3'd5,
        REG_EXT_CLOCK = 3'd6,
        REG_NONE      = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_CHROMATIC = 2'd0,
        MODE_DIATONIC  = 2'd1,
        MODE_FREE_A    = 2'd2,
        MODE_FREE_B    = 2'd3
    } t_row_mode;

    typedef struct packed {
        logic [31:0] row_one_levels;
        logic [31:0] row_two_levels;
        logic [31:0] row_three_levels;
        logic [8:0]  row_modes;
        logic [3:0]  step_setting;
        logic [31:0] phase_increment;
        logic        use_external_clock;
    } t_cfg;

    typedef struct packed {
        logic signed [14:0] steps_cv_mv;
        logic signed [14:0] reset_mv;
        logic signed [14:0] ext_clock_mv;
        logic [7:0]         gate_buttons;
        logic               reset_button;
        logic               run_button;
    } t_tick_in;

    typedef struct packed {
        logic [7:0] pattern_out;
        logic       is_running;
        logic [2:0] current_step;
        logic [9:0] row_three_pitch;
        logic [9:0] row_two_pitch;
        logic [9:0] row_one_pitch;
        logic       gate_out;
        logic [7:0] step_gates;
    } t_tick_out;

    // Schmitt trigger: assert at 1 V or more, release at 0 V or less.
    function automatic logic schmitt_next(input logic st, input logic signed [15:0] mv);
        logic res;
        if (st) begin
            res = (mv > 16'sd0);
        end else begin
            res = (mv >= 16'(THRESH_MV));
        end
        return res;
    endfunction

    function automatic logic [4:0] diatonic_semis(input logic [3:0] lvl);
        logic [4:0] res;
        unique case (lvl)
            4'd0:    res = 5'd0;
            4'd1:    res = 5'd2;
            4'd2:    res = 5'd4;
            4'd3:    res = 5'd5;
            4'd4:    res = 5'd7;
            4'd5:    res = 5'd9;
            4'd6:    res = 5'd11;
            4'd7:    res = 5'd12;
            4'd8:    res = 5'd14;
            4'd9:    res = 5'd16;
            4'd10:   res = 5'd17;
            4'd11:   res = 5'd19;
            default: res = 5'd21;
        endcase
        return res;
    endfunction

    // Pitch of one row at the given step, in 1/60 V units.
    function automatic logic [9:0] row_pitch(input logic [31:0] levels,
                                             input logic [2:0]  step,
                                             input logic [2:0]  bits);
        logic [3:0] lvl;
        logic [9:0] res;
        lvl = levels[{step, 2'b00} +: 4];
        if (lvl > 4'(LEVEL_MAX)) begin
            lvl = 4'(LEVEL_MAX);
        end
        unique case (t_row_mode'(bits[1:0]))
            MODE_CHROMATIC: res = 10'(lvl) * 10'd5;
            MODE_DIATONIC:  res = 10'(diatonic_semis(lvl)) * 10'd5;
            default:        res = bits[2] ? 10'(lvl) * 10'd60 : 10'(lvl) * 10'd6;
        endcase
        return res;
    endfunction

endpackage

FILE: hdl/tsq_cfg_regs.sv
// ----------------------------------------------------------------------------
// tsq_cfg_regs
// APB register bank: row levels, modes, step knob, phase increment, clock select.
// ----------------------------------------------------------------------------
module tsq_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tsq_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output tsq_pkg::t_cfg                 o_cfg
);
    import tsq_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite & pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_one_levels     <= '0;
            r_cfg.row_two_levels     <= '0;
            r_cfg.row_three_levels   <= '0;
            r_cfg.row_modes          <= '0;
            r_cfg.step_setting       <= STEP_SETTING_RST;
            r_cfg.phase_increment    <= PHASE_INC_RST;
            r_cfg.use_external_clock <= 1'b0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_ROW_ONE:   r_cfg.row_one_levels     <= pwdata;
                REG_ROW_TWO:   r_cfg.row_two_levels     <= pwdata;
                REG_ROW_THREE: r_cfg.row_three_levels   <= pwdata;
                REG_MODES:     r_cfg.row_modes          <= pwdata[8:0];
                REG_STEPS:     r_cfg.step_setting       <= pwdata[3:0];
                REG_PHASE_INC: r_cfg.phase_increment    <= pwdata;
                REG_EXT_CLOCK: r_cfg.use_external_clock <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_ROW_ONE:   prdata = r_cfg.row_one_levels;
            REG_ROW_TWO:   prdata = r_cfg.row_two_levels;
            REG_ROW_THREE: prdata = r_cfg.row_three_levels;
            REG_MODES:     prdata = 32'(r_cfg.row_modes);
            REG_STEPS:     prdata = 32'(r_cfg.step_setting);
            REG_PHASE_INC: prdata = r_cfg.phase_increment;
            REG_EXT_CLOCK: prdata = 32'(r_cfg.use_external_clock);
            default:       prdata = '0;
        endcase
    end

endmodule

FILE: hdl/tsq_core.sv
// ----------------------------------------------------------------------------
// tsq_core
// Sequencer state and the one-tick update: triggers, clock, step, gates, pitch.
// ----------------------------------------------------------------------------
module tsq_core #(
    parameter int STEPS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  tsq_pkg::t_cfg       i_cfg,
    input  tsq_pkg::t_tick_in   i_tick,
    output tsq_pkg::t_tick_out  o_res
);
    import tsq_pkg::*;

    localparam int Lim = (STEPS < LANES) ? STEPS : LANES;

    logic [2:0]  r_step;
    logic [31:0] r_phase;
    logic        r_running;
    logic [7:0]  r_pattern;
    logic        r_run_trig;
    logic        r_rst_trig;
    logic        r_clk_trig;
    logic [7:0]  r_btn_trig;

    logic [2:0]  n_step;
    logic [31:0] n_phase;
    logic        n_running;
    logic [7:0]  n_pattern;
    logic        n_run_trig;
    logic        n_rst_trig;
    logic        n_clk_trig;
    logic [7:0]  n_btn_trig;

    logic signed [16:0] w_total;
    logic signed [15:0] w_rst_mv;
    logic [3:0]         w_count;
    logic [3:0]         w_next;
    logic [2:0]         w_adv_step;
    logic [32:0]        w_sum;
    logic               w_gate_in;
    logic               w_cur;

    // Rounded step count, clamped: count reaches k once total >= k*1000 - 500.
    assign w_total = $signed(17'(i_cfg.step_setting) * 17'd1000) + 17'(i_tick.steps_cv_mv);

    always_comb begin
        w_count = 4'd1;
        for (int k = 2; k <= LANES; k++) begin
            if (k <= Lim && w_total >= $signed(17'(k * 1000 - 500))) begin
                w_count = 4'(k);
            end
        end
    end

    assign w_next     = 4'(r_step) + 4'd1;
    assign w_adv_step = (w_next >= w_count) ? 3'd0 : w_next[2:0];
    assign w_sum      = 33'(r_phase) + 33'(i_cfg.phase_increment);
    assign w_rst_mv   = 16'(i_tick.reset_mv) + (i_tick.reset_button ? 16'(THRESH_MV) : 16'sd0);

    always_comb begin
        n_run_trig = i_tick.run_button;
        n_running  = r_running ^ (i_tick.run_button & ~r_run_trig);

        n_step     = r_step;
        n_phase    = r_phase;
        n_clk_trig = r_clk_trig;
        w_gate_in  = 1'b0;
        if (n_running) begin
            if (i_cfg.use_external_clock) begin
                n_clk_trig = schmitt_next(r_clk_trig, 16'(i_tick.ext_clock_mv));
                if (n_clk_trig && !r_clk_trig) begin
                    n_step  = w_adv_step;
                    n_phase = '0;
                end
                w_gate_in = n_clk_trig;
            end else begin
                n_phase = w_sum[31:0];
                if (w_sum[32]) begin
                    n_step  = w_adv_step;
                    n_phase = '0;
                end
                w_gate_in = ~n_phase[31];
            end
        end

        n_rst_trig = schmitt_next(r_rst_trig, w_rst_mv);
        if (n_rst_trig && !r_rst_trig) begin
            n_step  = 3'd0;
            n_phase = '0;
        end

        // Toggle a step's gate on its button's press.
        n_btn_trig = i_tick.gate_buttons;
        n_pattern  = r_pattern ^ (i_tick.gate_buttons & ~r_btn_trig);
    end

    assign w_cur = n_pattern[n_step];

    always_comb begin
        o_res.step_gates      = (n_running && w_gate_in && w_cur) ? (8'd1 << n_step) : 8'd0;
        o_res.gate_out        = w_gate_in & w_cur;
        o_res.row_one_pitch   = row_pitch(i_cfg.row_one_levels, n_step, i_cfg.row_modes[2:0]);
        o_res.row_two_pitch   = row_pitch(i_cfg.row_two_levels, n_step, i_cfg.row_modes[5:3]);
        o_res.row_three_pitch = row_pitch(i_cfg.row_three_levels, n_step,
                                          i_cfg.row_modes[8:6]);
        o_res.current_step    = n_step;
        o_res.is_running      = n_running;
        o_res.pattern_out     = n_pattern;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= '0;
            r_phase    <= '0;
            r_running  <= 1'b1;
            r_pattern  <= '1;
            r_run_trig <= 1'b1;
            r_rst_trig <= 1'b1;
            r_clk_trig <= 1'b1;
            r_btn_trig <= '1;
        end else if (i_fire) begin
            r_step     <= n_step;
            r_phase    <= n_phase;
            r_running  <= n_running;
            r_pattern  <= n_pattern;
            r_run_trig <= n_run_trig;
            r_rst_trig <= n_rst_trig;
            r_clk_trig <= n_clk_trig;
            r_btn_trig <= n_btn_trig;
        end
    end

endmodule

FILE: hdl/three_row_step_sequencer_unit.sv
// ----------------------------------------------------------------------------
// three_row_step_sequencer_unit
// Eight-step, three-row CV/gate sequencer, one input item per sample tick.
// ----------------------------------------------------------------------------
// Each input item is one sample tick; each produces exactly one result item.
// An item is registered on entry, the state update and pitch lookup run on
// it combinationally, and the result lands in an output register, so the block
// takes one item per clock unless stalled. Flow stalls only when the output
// register is full and m_axis_tready is low. The user must write registers
// over APB only while the stream is idle; the block does not enforce this.
module three_row_step_sequencer_unit #(
    parameter int STEPS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tsq_pkg::PADDR_W-1:0]          paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // run_button, reset_button, gate_buttons[7:0], ext_clock_mv[14:0],
    // reset_mv[14:0], steps_cv_mv[14:0], zero pad
    input  logic [tsq_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // step_gates[7:0], gate_out, row_one_pitch[9:0], row_two_pitch[9:0],
    // row_three_pitch[9:0], current_step[2:0], is_running, pattern_out[7:0],
    // zero pad
    output logic [tsq_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
    import tsq_pkg::*;

    t_cfg      w_cfg;
    t_tick_in  r_in;
    logic      r_in_valid;
    t_tick_out w_res;
    t_tick_out r_out;
    logic      r_out_valid;
    logic      w_adv;

    assign w_adv         = r_in_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_in_valid | w_adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out);

    tsq_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tsq_core #(
        .STEPS (STEPS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_adv),
        .i_cfg   (w_cfg),
        .i_tick  (r_in),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: capture on accept, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= t_tick_in'(s_axis_tdata[$bits(t_tick_in)-1:0]);
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

endmodule

FILE: verif/three_row_step_sequencer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_row_step_sequencer_unit_tb
// Self-checking bench for the three-row step sequencer. A directed table of
// ticks, with fixed results typed in for the simplest rows, comes first. It is
// followed by phases of random panel activity under changing register settings
// and stream back-pressure. Each result is checked field by field against its
// typed-in result, else a cycle-free model of sequencer state in the bench.
// ----------------------------------------------------------------------------
module three_row_step_sequencer_unit_tb;
    import tsq_pkg::*;

    localparam int SEQ_STEPS        = 8;
    localparam int SINK_HOLD_CYCLES = 64;
    localparam int RAND_PHASES      = 12;
    localparam int ITEMS_PER_PHASE  = 46;
    localparam int MAJOR_SEMIS [13] = '{0, 2, 4, 5, 7, 9, 11, 12, 14, 16, 17, 19, 21};

    typedef struct {
        logic        has_cfg;
        t_reg_idx    cfg_reg;
        logic [31:0] cfg_val;
        t_tick_in    stim;
        logic        has_want;
        t_tick_out   want;
    } t_directed_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Shadow of the registers and of the sequencer state
    t_cfg        seq_cfg;
    logic [2:0]  step_idx;
    logic [31:0] phase_acc;
    logic        running;
    logic [7:0]  gate_en;
    logic        run_hi;
    logic        rst_hi;
    logic        clk_hi;
    logic [7:0]  btn_hi;

    // Panel levels carried between random ticks
    logic        run_lvl;
    logic        rst_lvl;
    logic        clk_lvl;
    logic [7:0]  gate_lvl;
    int          cv_mv;

    t_tick_out     ticks_due[$];
    t_directed_row directed_rows[$];
    t_tick_out     got_tick;
    t_tick_out     due_tick;
    int            mismatch_count;
    int            src_idle_pct;
    int            sink_idle_pct;
    logic          sink_hold_req;

    three_row_step_sequencer_unit #(
        .STEPS(SEQ_STEPS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequencer model
    // ------------------------------------------------------------------------

    // Returns {trigger state, rising edge}.
    function automatic logic [1:0] trig_step(input logic hi, input int mv);
        logic rise;
        rise = !hi && (mv >= THRESH_MV);
        return {hi ? (mv > 0) : rise, rise};
    endfunction

    function automatic void jump_step(input int target, input int count);
        phase_acc = '0;
        step_idx  = (target >= count) ? 3'd0 : 3'(target);
    endfunction

    function automatic int row_level_pitch(input logic [31:0] levels, input logic [2:0] bits);
        int lv;
        lv = int'((levels >> (4 * step_idx)) & 32'hF);
        if (lv > LEVEL_MAX) begin
            lv = LEVEL_MAX;
        end
        case (t_row_mode'(bits[1:0]))
            MODE_CHROMATIC: return 5 * lv;
            MODE_DIATONIC:  return 5 * MAJOR_SEMIS[lv];
            default:        return bits[2] ? 60 * lv : 6 * lv;
        endcase
    endfunction

    function automatic t_tick_out sequencer_tick(input t_tick_in t);
        int        total;
        int        count;
        int        lim;
        logic [1:0] tr;
        logic [32:0] sum;
        logic      gate_in;
        logic      cur;
        t_tick_out r;
        lim   = (SEQ_STEPS < LANES) ? SEQ_STEPS : LANES;
        total = int'(seq_cfg.step_setting) * 1000 + int'($signed(t.steps_cv_mv));
        // round half away from zero, then clamp
        if (total >= 0) begin
            count = (total + 500) / 1000;
        end else begin
            count = -((-total + 500) / 1000);
        end
        if (count < 1) begin
            count = 1;
        end
        if (count > lim) begin
            count = lim;
        end

        tr = trig_step(run_hi, t.run_button ? THRESH_MV : 0);
        run_hi = tr[1];
        if (tr[0]) begin
            running = ~running;
        end

        gate_in = 1'b0;
        if (running) begin
            if (seq_cfg.use_external_clock) begin
                tr = trig_step(clk_hi, int'($signed(t.ext_clock_mv)));
                clk_hi = tr[1];
                if (tr[0]) begin
                    jump_step(int'(step_idx) + 1, count);
                end
                gate_in = clk_hi;
            end else begin
                sum = {1'b0, phase_acc} + {1'b0, seq_cfg.phase_increment};
                phase_acc = sum[31:0];
                if (sum[32]) begin
                    jump_step(int'(step_idx) + 1, count);
                end
                gate_in = ~phase_acc[31];
            end
        end

        tr = trig_step(rst_hi, int'($signed(t.reset_mv)) + (t.reset_button ? THRESH_MV : 0));
        rst_hi = tr[1];
        if (tr[0]) begin
            jump_step(0, count);
        end

        for (int i = 0; i < 8; i++) begin
            tr = trig_step(btn_hi[i], t.gate_buttons[i] ? THRESH_MV : 0);
            btn_hi[i] = tr[1];
            if (tr[0]) begin
                gate_en[i] = ~gate_en[i];
            end
        end

        cur               = gate_en[step_idx];
        r.step_gates      = (running && gate_in && cur) ? (8'd1 << step_idx) : 8'd0;
        r.gate_out        = gate_in & cur;
        r.row_one_pitch   = 10'(row_level_pitch(seq_cfg.row_one_levels, seq_cfg.row_modes[2:0]));
        r.row_two_pitch   = 10'(row_level_pitch(seq_cfg.row_two_levels, seq_cfg.row_modes[5:3]));
        r.row_three_pitch = 10'(row_level_pitch(seq_cfg.row_three_levels,
                                                seq_cfg.row_modes[8:6]));
        r.current_step    = step_idx;
        r.is_running      = running;
        r.pattern_out     = gate_en;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < 40) begin
            $display("%0t: %s mismatch, got %0h expected %0h", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic compare_tick(input t_tick_out got, input t_tick_out want);
        if (got.step_gates !== want.step_gates)
            report_mismatch("step_gates", got.step_gates, want.step_gates);
        if (got.gate_out !== want.gate_out)
            report_mismatch("gate_out", got.gate_out, want.gate_out);
        if (got.row_one_pitch !== want.row_one_pitch)
            report_mismatch("row_one_pitch", got.row_one_pitch, want.row_one_pitch);
        if (got.row_two_pitch !== want.row_two_pitch)
            report_mismatch("row_two_pitch", got.row_two_pitch, want.row_two_pitch);
        if (got.row_three_pitch !== want.row_three_pitch)
            report_mismatch("row_three_pitch", got.row_three_pitch, want.row_three_pitch);
        if (got.current_step !== want.current_step)
            report_mismatch("current_step", got.current_step, want.current_step);
        if (got.is_running !== want.is_running)
            report_mismatch("is_running", got.is_running, want.is_running);
        if (got.pattern_out !== want.pattern_out)
            report_mismatch("pattern_out", got.pattern_out, want.pattern_out);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_tick = m_axis_tdata[$bits(t_tick_out)-1:0];
            if (ticks_due.size() == 0) begin
                report_mismatch("unexpected item", got_tick, 0);
            end else begin
                due_tick = ticks_due.pop_front();
                compare_tick(got_tick, due_tick);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                m_axis_tready = 1'b0;
                repeat (SINK_HOLD_CYCLES) @(negedge i_clk);
            end
            m_axis_tready = ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic reg_write(input t_reg_idx idx, input logic [31:0] val);
        logic [31:0] readback;
        case (idx)
            REG_ROW_ONE: begin
                seq_cfg.row_one_levels = val;
                readback = val;
            end
            REG_ROW_TWO: begin
                seq_cfg.row_two_levels = val;
                readback = val;
            end
            REG_ROW_THREE: begin
                seq_cfg.row_three_levels = val;
                readback = val;
            end
            REG_MODES: begin
                seq_cfg.row_modes = val[8:0];
                readback = 32'(val[8:0]);
            end
            REG_STEPS: begin
                seq_cfg.step_setting = val[3:0];
                readback = 32'(val[3:0]);
            end
            REG_PHASE_INC: begin
                seq_cfg.phase_increment = val;
                readback = val;
            end
            REG_EXT_CLOCK: begin
                seq_cfg.use_external_clock = val[0];
                readback = 32'(val[0]);
            end
            default: readback = '0;
        endcase
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = PADDR_W'({idx, 2'b00});
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== readback) begin
            report_mismatch("prdata", prdata, readback);
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Offer one tick; after it is taken, queue what it should produce.
    task automatic send_tick(input t_tick_in t, input logic fixed, input t_tick_out fixed_res);
        t_tick_out pred;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = IN_TDATA_W'({$urandom, $urandom});
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = IN_TDATA_W'(t);
        do @(posedge i_clk); while (!s_axis_tready);
        pred = sequencer_tick(t);
        ticks_due.push_back(fixed ? fixed_res : pred);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic wait_ticks_drained();
        while (ticks_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    function automatic t_tick_in tick_of(input logic run, input logic rst,
                                         input logic [7:0] gb, input int ext,
                                         input int rmv, input int cv);
        t_tick_in t;
        t.run_button   = run;
        t.reset_button = rst;
        t.gate_buttons = gb;
        t.ext_clock_mv = 15'(ext);
        t.reset_mv     = 15'(rmv);
        t.steps_cv_mv  = 15'(cv);
        return t;
    endfunction

    function automatic t_tick_out result_of(input logic [7:0] sg, input logic go,
                                            input logic [2:0] step, input logic run,
                                            input logic [7:0] pat);
        t_tick_out r;
        r                 = '0;
        r.step_gates      = sg;
        r.gate_out        = go;
        r.current_step    = step;
        r.is_running      = run;
        r.pattern_out     = pat;
        return r;
    endfunction

    task automatic add_row(input logic has_cfg, input t_reg_idx r, input logic [31:0] v,
                           input t_tick_in s, input logic has_want, input t_tick_out w);
        t_directed_row row;
        row.has_cfg  = has_cfg;
        row.cfg_reg  = r;
        row.cfg_val  = v;
        row.stim     = s;
        row.has_want = has_want;
        row.want     = w;
        directed_rows.push_back(row);
    endtask

    // Mostly near thresholds and at the ends of the 15-bit range.
    function automatic int wild_mv();
        case ($urandom_range(5))
            0:       return THRESH_MV - 1 + int'($urandom_range(2));
            1:       return int'($urandom_range(2)) - 1;
            2:       return $urandom_range(1) ? 12000 : -12000;
            3:       return $urandom_range(1) ? 16383 : -16384;
            4:       return int'($urandom_range(24000)) - 12000;
            default: return int'($urandom_range(32767)) - 16384;
        endcase
    endfunction

    function automatic t_tick_in next_panel_tick();
        t_tick_in   t;
        logic [63:0] raw;
        if ($urandom_range(99) < 10) begin
            raw = {$urandom, $urandom};
            t   = raw[$bits(t_tick_in)-1:0];
            return t;
        end
        if ($urandom_range(99) < 4) run_lvl = ~run_lvl;
        if ($urandom_range(99) < 5) rst_lvl = ~rst_lvl;
        if ($urandom_range(99) < 12) gate_lvl ^= 8'(1 << $urandom_range(7));
        if ($urandom_range(99) < 2) gate_lvl = 8'($urandom);
        if ($urandom_range(99) < 30) clk_lvl = ~clk_lvl;
        if ($urandom_range(99) < 10) cv_mv = wild_mv();
        t.run_button   = run_lvl;
        t.reset_button = rst_lvl;
        t.gate_buttons = gate_lvl;
        if ($urandom_range(99) < 15) begin
            t.ext_clock_mv = 15'(wild_mv());
        end else if (clk_lvl) begin
            t.ext_clock_mv = 15'($urandom_range(12000, THRESH_MV));
        end else begin
            t.ext_clock_mv = 15'(-int'($urandom_range(12000)));
        end
        t.reset_mv    = ($urandom_range(99) < 12) ? 15'(wild_mv()) : 15'(0);
        t.steps_cv_mv = 15'(cv_mv);
        return t;
    endfunction

    function automatic logic [31:0] pick_increment();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $urandom_range(32'hFFFF_FFFF, 32'h2000_0000);
            2:       return 32'hFFFF_FFFF - $urandom_range(255);
            default: return $urandom_range(32'h0FFF_FFFF);
        endcase
    endfunction

    initial begin
        logic [31:0] vals [7];
        int          mode;

        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        sink_hold_req  = 1'b0;
        mismatch_count = 0;
        src_idle_pct   = 21;
        sink_idle_pct  = 88;

        seq_cfg                 = '0;
        seq_cfg.step_setting    = STEP_SETTING_RST;
        seq_cfg.phase_increment = PHASE_INC_RST;
        step_idx  = '0;
        phase_acc = '0;
        running   = 1'b1;
        gate_en   = 8'hFF;
        run_hi    = 1'b1;
        rst_hi    = 1'b1;
        clk_hi    = 1'b1;
        btn_hi    = 8'hFF;
        run_lvl   = 1'b0;
        rst_lvl   = 1'b0;
        clk_lvl   = 1'b0;
        gate_lvl  = '0;
        cv_mv     = 0;

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: run toggle and gate toggle with fixed results
        add_row(0, REG_NONE, 0, tick_of(0, 0, 8'h00, 0, 0, 0), 1, result_of(8'h01, 1, 0, 1, 8'hFF));
        add_row(0, REG_NONE, 0, tick_of(1, 0, 8'h00, 0, 0, 0), 1, result_of(8'h00, 0, 0, 0, 8'hFF));
        add_row(0, REG_NONE, 0, tick_of(1, 0, 8'h01, 0, 0, 0), 1, result_of(8'h00, 0, 0, 0, 8'hFE));
        add_row(0, REG_NONE, 0, tick_of(0, 0, 8'h00, 0, 0, 0), 1, result_of(8'h00, 0, 0, 0, 8'hFE));
        add_row(0, REG_NONE, 0, tick_of(1, 0, 8'h00, 0, 0, 0), 1, result_of(8'h00, 0, 0, 1, 8'hFE));
        add_row(0, REG_NONE, 0, tick_of(1, 0, 8'h01, 0, 0, 0), 1, result_of(8'h01, 1, 0, 1, 8'hFF));
        // Phase overflow at the largest increment, step count clamping and rounding
        add_row(1, REG_PHASE_INC, 32'hFFFF_FFFF, tick_of(0, 0, 8'h00, 0, 0, 0), 0, '0);
        add_row(0, REG_NONE, 0, tick_of(0, 0, 8'h00, 12000, 0, 0), 0, '0);
        add_row(0, REG_NONE, 0, tick_of(0, 0, 8'h00, -12000, 0, -12000), 0, '0);
        add_row(0, REG_NONE, 0, tick_of(0, 0, 8'h00, 0, 0, 12000), 0, '0);
        add_row(1, REG_STEPS, 32'd1, tick_of(0, 0, 8'h00, 0, 0, 1499), 0, '0);
        add_row(0, REG_NONE, 0, tick_of(0, 0, 8'h00, 0, 0, 1500), 0, '0);
        add_row(0, REG_NONE, 0, tick_of(0, 0, 8'h00, 0, 0, -1500), 0, '0);
        // External clock hysteresis, reset jack and reset button
        add_row(1, REG_EXT_CLOCK, 32'd1, tick_of(0, 0, 8'h00, 999, 0, 3000), 0, '0);
        add_row(0, REG_NONE, 0, tick_of(0, 0, 8'h00, 0, 0, 3000), 0, '0);
        add_row(0, REG_NONE, 0, tick_of(0, 0, 8'h00, 999, 0, 3000), 0, '0);
        add_row(0, REG_NONE, 0, tick_of(0, 0, 8'h00, 1000, 0, 3000), 0, '0);
        add_row(0, REG_NONE, 0, tick_of(0, 0, 8'h00, -12000, 12000, 3000), 0, '0);
        add_row(0, REG_NONE, 0, tick_of(0, 1, 8'h00, 0, -12000, 3000), 0, '0);
        add_row(0, REG_NONE, 0, tick_of(0, 1, 8'h00, 0, 0, 3000), 0, '0);
        add_row(0, REG_NONE, 0, tick_of(0, 0, 8'hFF, 16383, -16384, 16383), 0, '0);
        add_row(0, REG_NONE, 0, tick_of(0, 0, 8'h00, -16384, 999, -16384), 0, '0);
        // Pitch rows: saturated levels and every mode
        add_row(1, REG_ROW_ONE, 32'hFFFF_FFFF, tick_of(0, 0, 8'h00, 12000, 0, 0), 0, '0);
        add_row(1, REG_ROW_TWO, 32'hFEDC_BA98, tick_of(0, 0, 8'hAA, 0, 0, 0), 0, '0);
        add_row(1, REG_ROW_THREE, 32'h7654_3210, tick_of(0, 0, 8'h55, 1000, 0, 0), 0, '0);
        add_row(1, REG_MODES, 32'h1FF, tick_of(0, 0, 8'h00, -1, 0, 0), 0, '0);
        add_row(1, REG_MODES, 32'h10A, tick_of(0, 0, 8'h00, 1500, 0, 0), 0, '0);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].has_cfg) begin
                wait_ticks_drained();
                reg_write(directed_rows[i].cfg_reg, directed_rows[i].cfg_val);
            end
            send_tick(directed_rows[i].stim, directed_rows[i].has_want, directed_rows[i].want);
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            mode          = p / 4;
            src_idle_pct  = (mode == 0) ? 21 : ((mode == 1) ? 88 : 0);
            sink_idle_pct = (mode == 0) ? 88 : ((mode == 1) ? 21 : 0);
            wait_ticks_drained();
            if (p == 0) begin
                vals = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1FF, 32'd8,
                         32'hFFFF_FFFF, 32'd0};
            end else if (p == 1) begin
                vals = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd1};
            end else begin
                vals[0] = $urandom;
                vals[1] = $urandom;
                vals[2] = $urandom;
                vals[3] = $urandom_range(511);
                vals[4] = $urandom_range(8, 1);
                vals[5] = pick_increment();
                vals[6] = $urandom_range(1);
            end
            for (int r = 0; r < 7; r++) begin
                reg_write(t_reg_idx'(r), vals[r]);
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // long sink stall while items keep coming
                if (p == 1 && n == 5) begin
                    sink_hold_req = 1'b1;
                end
                // let everything in flight come out before going on
                if (p == 5 && n == 23) begin
                    wait_ticks_drained();
                end
                send_tick(next_panel_tick(), 1'b0, '0);
            end
        end

        wait_ticks_drained();
        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
